// File: design/multi_queue_fifo_manager_defines.svh
// assertion macros for the multi-queue fifo manager
// included by the top level, no other dependencies
`ifndef MULTI_QUEUE_FIFO_MANAGER_DEFINES_SVH
`define MULTI_QUEUE_FIFO_MANAGER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define MQFM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqfm assertion failed");

// next-cycle implication, disabled while reset is active
`define MQFM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqfm assertion failed");

`endif

// File: design/mqfm_pkg.sv
// shared types and constants of the multi-queue fifo manager
// no dependencies
package mqfm_pkg;

  localparam int unsigned NUM_QUEUES_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned QUEUE_ID_W = 3;
  localparam int unsigned HANDLE_W   = 31;
  localparam int unsigned CAPACITY_W = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FILL_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_ENQUEUE = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_NOFREE  = 3'd4,
    ST_CLAMPED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_META = 4'b0010,
    S_SLOT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

// File: design/multi_queue_fifo_manager.sv
// multi-queue fifo manager: one request in, one result out.
// a request is captured with the read of its queue state; S_META writes the state back and
// registers the result, a dequeue that returns a handle then passes S_SLOT to take the handle
// from the registered slot-memory read, and S_DONE loads the output register once it is free.
// a new request is taken only back in S_IDLE. reset clears the control state and the count of
// created queues; the memories are not cleared, every queue's state is written by its create before any use.
`include "multi_queue_fifo_manager_defines.svh"

module multi_queue_fifo_manager #(
  parameter int unsigned NUM_QUEUES  = mqfm_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = mqfm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mqfm_pkg::REQ_W-1:0]        req_type_i,
  input  logic [mqfm_pkg::QUEUE_ID_W-1:0]   queue_id_i,
  input  logic [mqfm_pkg::HANDLE_W-1:0]     message_handle_i,
  input  logic [mqfm_pkg::CAPACITY_W-1:0]   capacity_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mqfm_pkg::STATUS_W-1:0]     status_o,
  output logic [mqfm_pkg::QUEUE_ID_W-1:0]   queue_number_o,
  output logic [mqfm_pkg::HANDLE_W-1:0]     handle_out_o,
  output logic [mqfm_pkg::FILL_W-1:0]       fill_level_o
);
  import mqfm_pkg::*;

  localparam int unsigned QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QC_W   = $clog2(NUM_QUEUES + 1);
  localparam int unsigned SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned QCMP_W = (QC_W > QUEUE_ID_W) ? QC_W : QUEUE_ID_W;
  localparam int unsigned CAPC_W = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;

  typedef struct packed {
    logic [PTR_W-1:0] rp;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] cap;
  } meta_t;

  state_e state_q, state_d;
  logic [QC_W-1:0] qc_q, qc_d;
  logic out_valid_q, out_valid_d;

  // captured request
  req_e                  req_q;
  logic [QUEUE_ID_W-1:0] qid_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [CAPACITY_W-1:0] cap_q;

  // memories
  meta_t             meta_mem [NUM_QUEUES];
  meta_t             meta_rd_q;
  logic [HANDLE_W-1:0] slot_mem [SLOTS];
  logic [HANDLE_W-1:0] slot_rd_q;

  logic              meta_we;
  logic [QID_W-1:0]  meta_waddr;
  meta_t             meta_wdata;
  logic              slot_we, slot_re;
  logic [SA_W-1:0]   slot_waddr, slot_raddr;

  // result before the output register
  status_e               res_status_q, res_status_d;
  logic [QUEUE_ID_W-1:0] res_qnum_q, res_qnum_d;
  logic [HANDLE_W-1:0]   res_handle_q;
  logic [FILL_W-1:0]     res_fill_q, res_fill_d;

  // output register
  status_e               out_status_q;
  logic [QUEUE_ID_W-1:0] out_qnum_q;
  logic [HANDLE_W-1:0]   out_handle_q;
  logic [FILL_W-1:0]     out_fill_q;

  logic in_acc, out_load;
  logic known, qfree, cap_big;
  logic [QID_W-1:0] qidx;
  logic [SUM_W-1:0] ring_sum;
  logic [PTR_W-1:0] wr_pos, rp_next;
  logic [CNT_W-1:0] cap_eff;
  logic [SA_W-1:0]  base;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign qidx     = QID_W'(qid_q);
  assign known    = QCMP_W'(qid_q) < QCMP_W'(qc_q);
  assign qfree    = (qc_q != QC_W'(NUM_QUEUES));
  assign cap_big  = CAPC_W'(cap_q) > CAPC_W'(QUEUE_DEPTH);
  assign cap_eff  = cap_big ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_q);
  // rp + fill stays below twice the depth, one subtract wraps it
  assign ring_sum = SUM_W'(meta_rd_q.rp) + SUM_W'(meta_rd_q.fill);
  assign wr_pos   = (ring_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(ring_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(ring_sum);
  assign rp_next  = (meta_rd_q.rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : meta_rd_q.rp + 1'b1;
  assign base     = SA_W'(qidx) * SA_W'(QUEUE_DEPTH);

  always_comb begin
    state_d      = state_q;
    qc_d         = qc_q;
    meta_we      = 1'b0;
    meta_waddr   = qidx;
    meta_wdata   = meta_rd_q;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    slot_waddr   = base + SA_W'(wr_pos);
    slot_raddr   = base + SA_W'(meta_rd_q.rp);
    res_status_d = ST_OK;
    res_qnum_d   = qid_q;
    res_fill_d   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_META;
      end
      S_META: begin
        state_d = S_DONE;
        if (req_q == REQ_CREATE) begin
          if (!qfree) begin
            res_status_d = ST_NOFREE;
            res_qnum_d   = '0;
          end else begin
            meta_we         = 1'b1;
            meta_waddr      = QID_W'(qc_q);
            meta_wdata.rp   = '0;
            meta_wdata.fill = '0;
            meta_wdata.cap  = cap_eff;
            qc_d            = qc_q + 1'b1;
            res_status_d    = cap_big ? ST_CLAMPED : ST_OK;
            res_qnum_d      = QUEUE_ID_W'(qc_q);
          end
        end else if (!known) begin
          res_status_d = ST_UNKNOWN;
        end else begin
          unique case (req_q)
            REQ_ENQUEUE: begin
              if (meta_rd_q.fill >= meta_rd_q.cap) begin
                res_status_d = ST_FULL;
                res_fill_d   = FILL_W'(meta_rd_q.cap);
              end else begin
                slot_we         = 1'b1;
                meta_we         = 1'b1;
                meta_wdata.fill = meta_rd_q.fill + 1'b1;
                res_fill_d      = FILL_W'(meta_rd_q.fill + 1'b1);
              end
            end
            REQ_DEQUEUE: begin
              if (meta_rd_q.fill == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                slot_re         = 1'b1;
                meta_we         = 1'b1;
                meta_wdata.rp   = rp_next;
                meta_wdata.fill = meta_rd_q.fill - 1'b1;
                res_fill_d      = FILL_W'(meta_rd_q.fill - 1'b1);
                state_d         = S_SLOT;
              end
            end
            REQ_QUERY: res_fill_d = FILL_W'(meta_rd_q.fill);
            default: ;
          endcase
        end
      end
      S_SLOT: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      qc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qc_q        <= qc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture, queue-state read and queue-state write-back
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_e'(req_type_i);
      qid_q     <= queue_id_i;
      handle_q  <= message_handle_i;
      cap_q     <= capacity_i;
      meta_rd_q <= meta_mem[QID_W'(queue_id_i)];
    end
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= handle_q;
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_META) begin
      res_status_q <= res_status_d;
      res_qnum_q   <= res_qnum_d;
      res_fill_q   <= res_fill_d;
      res_handle_q <= '0;
    end else if (state_q == S_SLOT) begin
      res_handle_q <= slot_rd_q;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_qnum_q   <= res_qnum_q;
      out_handle_q <= res_handle_q;
      out_fill_q   <= res_fill_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign queue_number_o = out_qnum_q;
  assign handle_out_o   = out_handle_q;
  assign fill_level_o   = out_fill_q;

  `MQFM_ASSERT_IMP(a_qc_bound, clk_i, rst_ni, 1'b1, qc_q <= QC_W'(NUM_QUEUES))
  `MQFM_ASSERT_NXT(a_accept_meta, clk_i, rst_ni, in_acc, state_q == S_META)
  `MQFM_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE))
  `MQFM_ASSERT_IMP(a_nofree_result, clk_i, rst_ni, out_valid_q && out_status_q == ST_NOFREE, out_qnum_q == '0 && out_fill_q == '0 && qc_q == QC_W'(NUM_QUEUES))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for multi_queue_fifo_manager: directed and random request streams, with results
// checked against a behavioral predictor of the queue manager
// depends on mqfm_pkg and the design files only
module tb;
  import mqfm_pkg::*;

  localparam int NQ             = NUM_QUEUES_DEF;
  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    status_e                status;
    logic [QUEUE_ID_W-1:0]  qnum;
    logic [HANDLE_W-1:0]    handle;
    logic [FILL_W-1:0]      fill;
  } result_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [REQ_W-1:0]       req_type_i;
  logic [QUEUE_ID_W-1:0]  queue_id_i;
  logic [HANDLE_W-1:0]    message_handle_i;
  logic [CAPACITY_W-1:0]  capacity_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STATUS_W-1:0]    status_o;
  logic [QUEUE_ID_W-1:0]  queue_number_o;
  logic [HANDLE_W-1:0]    handle_out_o;
  logic [FILL_W-1:0]      fill_level_o;

  // predicted queue manager state
  logic [HANDLE_W-1:0] slot_mem [NQ][DEPTH];
  int                  head_ptr [NQ];
  int                  fill_cnt [NQ];
  int                  cap_lim  [NQ];
  int                  queues_made;

  result_t pending_results[$];
  int      mismatch_count;
  int      requests_sent;
  int      results_checked;
  int      kind_tally [4];
  int      status_tally [6];
  int      burst_left;
  int      hold_len;
  int      idle_cycles;

  multi_queue_fifo_manager dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .queue_id_i       (queue_id_i),
    .message_handle_i (message_handle_i),
    .capacity_i       (capacity_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .queue_number_o   (queue_number_o),
    .handle_out_o     (handle_out_o),
    .fill_level_o     (fill_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // applies one request to the predicted state and returns the result it causes
  function automatic result_t predict_request(req_e kind, logic [QUEUE_ID_W-1:0] qid,
                                              logic [HANDLE_W-1:0] handle,
                                              logic [CAPACITY_W-1:0] cap);
    result_t res;
    int      q;
    res = '{status: ST_OK, qnum: qid, handle: '0, fill: '0};
    q = qid;
    if (kind == REQ_CREATE) begin
      if (queues_made >= NQ) begin
        res.status = ST_NOFREE;
        res.qnum   = '0;
      end else begin
        res.qnum = queues_made[QUEUE_ID_W-1:0];
        if (cap > DEPTH) begin
          cap_lim[queues_made] = DEPTH;
          res.status = ST_CLAMPED;
        end else begin
          cap_lim[queues_made] = int'(cap);
        end
        head_ptr[queues_made] = 0;
        fill_cnt[queues_made] = 0;
        queues_made++;
      end
    end else if (q >= queues_made) begin
      res.status = ST_UNKNOWN;
    end else begin
      case (kind)
        REQ_ENQUEUE: begin
          if (fill_cnt[q] >= cap_lim[q]) begin
            res.status = ST_FULL;
            res.fill   = FILL_W'(cap_lim[q]);
          end else begin
            slot_mem[q][(head_ptr[q] + fill_cnt[q]) % DEPTH] = handle;
            fill_cnt[q]++;
            res.fill = FILL_W'(fill_cnt[q]);
          end
        end
        REQ_DEQUEUE: begin
          if (fill_cnt[q] == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.handle  = slot_mem[q][head_ptr[q]];
            head_ptr[q] = (head_ptr[q] + 1) % DEPTH;
            fill_cnt[q]--;
            res.fill = FILL_W'(fill_cnt[q]);
          end
        end
        default: res.fill = FILL_W'(fill_cnt[q]);
      endcase
    end
    return res;
  endfunction

  // offers one request, waits for acceptance, then maybe ends the burst with a gap
  task automatic send_request(req_e kind, int qid, logic [HANDLE_W-1:0] handle, int cap);
    result_t res;
    int      gap;
    in_valid_i       <= 1'b1;
    req_type_i       <= kind;
    queue_id_i       <= qid[QUEUE_ID_W-1:0];
    message_handle_i <= handle;
    capacity_i       <= cap[CAPACITY_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    res = predict_request(kind, qid[QUEUE_ID_W-1:0], handle, cap[CAPACITY_W-1:0]);
    pending_results.push_back(res);
    requests_sent++;
    kind_tally[kind]++;
    status_tally[res.status]++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering so the last transaction is not taken twice, then wait until every expected result is checked
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [HANDLE_W-1:0] rand_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return HANDLE_W'($urandom());
    endcase
  endfunction

  task automatic test_directed_cases();
    // requests to queues that do not exist yet
    send_request(REQ_ENQUEUE, 7, '1, 0);
    send_request(REQ_DEQUEUE, 0, '0, 0);
    send_request(REQ_QUERY,   3, '0, 0);
    // zero capacity queue rejects every handle
    send_request(REQ_CREATE,  0, '0, 0);
    send_request(REQ_ENQUEUE, 0, '1, 0);
    send_request(REQ_DEQUEUE, 0, '0, 0);
    // single slot queue: fill, overflow, query, drain, underflow
    send_request(REQ_CREATE,  5, '0, 1);
    send_request(REQ_ENQUEUE, 1, '1, 0);
    send_request(REQ_ENQUEUE, 1, '0, 0);
    send_request(REQ_QUERY,   1, '0, 0);
    send_request(REQ_DEQUEUE, 1, '0, 0);
    send_request(REQ_DEQUEUE, 1, '0, 0);
    // capacity above, at and just over the depth
    send_request(REQ_CREATE,  0, '1, 255);
    send_request(REQ_CREATE,  0, '0, DEPTH);
    send_request(REQ_CREATE,  0, '0, DEPTH + 1);
    send_request(REQ_ENQUEUE, 3, '0, 0);
    send_request(REQ_DEQUEUE, 3, '0, 0);
    send_request(REQ_QUERY,   2, '0, 0);
    wait_results_drained();
  endtask

  // mostly fill-then-drain runs on existing queues, the rest single random requests
  task automatic test_random_traffic(int n_items);
    int stop_at;
    int q;
    int run;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      if (queues_made > 0 && $urandom_range(0, 9) < 7) begin
        q   = $urandom_range(0, queues_made - 1);
        run = $urandom_range(1, cap_lim[q] + 2);
        repeat (run) begin
          if ($urandom_range(0, 5) == 0) send_request(REQ_QUERY, q, rand_handle(), 0);
          else send_request(REQ_ENQUEUE, q, rand_handle(), $urandom_range(0, 255));
        end
        if ($urandom_range(0, 2) == 0) run = fill_cnt[q] + 1;
        else run = $urandom_range(1, run + 2);
        repeat (run) send_request(REQ_DEQUEUE, q, rand_handle(), $urandom_range(0, 255));
      end else begin
        send_request(req_e'($urandom_range(0, 3)), $urandom_range(0, NQ - 1), rand_handle(),
                     $urandom_range(0, 255));
      end
    end
  endtask

  task automatic test_queue_exhaustion();
    while (queues_made < NQ) send_request(REQ_CREATE, $urandom_range(0, NQ - 1), '0,
                                          $urandom_range(2, DEPTH));
    repeat (3) send_request(REQ_CREATE, $urandom_range(0, NQ - 1), rand_handle(),
                            $urandom_range(0, 255));
  endtask

  // receiver holds off while requests keep coming, then the sender waits for the drain
  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    repeat (40) send_request(($urandom_range(0, 1) == 0) ? REQ_ENQUEUE : REQ_QUERY,
                             $urandom_range(0, NQ - 1), rand_handle(), 0);
    wait_results_drained();
  endtask

  // receiver stall patterns, plus long hold-offs on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       phase;
    mode      = RX_FREE;
    mode_left = 0;
    phase     = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        hold_len--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_RANDOM: out_stall_i <= ($urandom_range(0, 1) == 1);
          default:   out_stall_i <= (phase % 5 < 2);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d queue %0d",
                                  status_o, queue_number_o));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (queue_number_o !== want.qnum)
          report_mismatch($sformatf("queue_number got %0d want %0d", queue_number_o,
                                    want.qnum));
        if (handle_out_o !== want.handle)
          report_mismatch($sformatf("handle_out got %0h want %0h", handle_out_o,
                                    want.handle));
        if (fill_level_o !== want.fill)
          report_mismatch($sformatf("fill_level got %0d want %0d", fill_level_o,
                                    want.fill));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatch_count   = 0;
    requests_sent    = 0;
    results_checked  = 0;
    burst_left       = 0;
    hold_len         = 0;
    idle_cycles      = 0;
    queues_made      = 0;
    kind_tally       = '{default: 0};
    status_tally     = '{default: 0};
    head_ptr         = '{default: 0};
    fill_cnt         = '{default: 0};
    cap_lim          = '{default: 0};
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    req_type_i       <= REQ_QUERY;
    queue_id_i       <= '0;
    message_handle_i <= '0;
    capacity_i       <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(700);
    test_queue_exhaustion();
    test_backpressure();
    test_random_traffic(800);

    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d requests: %0d create, %0d enqueue, %0d dequeue, %0d query",
             requests_sent, kind_tally[REQ_CREATE], kind_tally[REQ_ENQUEUE],
             kind_tally[REQ_DEQUEUE], kind_tally[REQ_QUERY]);
    $display("%0d checked; ok %0d, full %0d, empty %0d, unknown %0d, no free %0d, clamped %0d",
             results_checked, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_EMPTY], status_tally[ST_UNKNOWN], status_tally[ST_NOFREE],
             status_tally[ST_CLAMPED]);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/mqfm_pkg.sv
design/multi_queue_fifo_manager.sv
tb/tb.sv
